@@ rtl/lpp_pkg.sv @@
// Package for the lidar polar-to-pixel unit: beat types, register indexes,
// the CORDIC arctangent table and the fixed constants. No dependencies.
package lpp_pkg;

	// Input beat
	typedef struct packed {
		logic [15:0] range_sample;
		logic [11:0] sample_index;
		logic        scan_last;
	} lpp_in_t;

	// Result beat
	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic        point_valid;
		logic        scan_end;
	} lpp_out_t;

	// Configuration register file contents
	typedef struct packed {
		logic [15:0] sensor_range_min;
		logic [15:0] sensor_range_max;
		logic [15:0] gate_min;
		logic [15:0] gate_max;
		logic [23:0] angle_start;
		logic [23:0] angle_step;
		logic [23:0] rotation;
		logic [12:0] image_size;
	} lpp_cfg_t;

	// Classified sample handed from front to back
	typedef struct packed {
		logic [15:0] range_sample;
		logic [23:0] theta;
		logic        range_ok;
		logic        scan_last;
	} lpp_work_t;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 24;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_SENSOR_MIN = 4'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SENSOR_MAX = 4'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_GATE_MIN   = 4'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_GATE_MAX   = 4'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_START = 4'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_STEP = 4'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_ROTATION   = 4'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_SIZE = 4'd7;

	// CORDIC start value 1/K in Q2.30
	localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

	// Width of the divide quotient (|q| < image_size/2)
	localparam int QUOT_W = 12;

	// atan(2^-i) in binary angle units (2^24 per turn)
	function automatic logic [21:0] atan_val(input int i);
		logic [21:0] v;
		case (i)
			0:  v = 22'd2097152;
			1:  v = 22'd1238021;
			2:  v = 22'd654136;
			3:  v = 22'd332050;
			4:  v = 22'd166669;
			5:  v = 22'd83416;
			6:  v = 22'd41718;
			7:  v = 22'd20860;
			8:  v = 22'd10430;
			9:  v = 22'd5215;
			10: v = 22'd2608;
			11: v = 22'd1304;
			12: v = 22'd652;
			13: v = 22'd326;
			14: v = 22'd163;
			15: v = 22'd81;
			16: v = 22'd41;
			17: v = 22'd20;
			18: v = 22'd10;
			19: v = 22'd5;
			20: v = 22'd3;
			21: v = 22'd1;
			22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/lpp_front.sv @@
// Front end: sample angle and range classification for one input beat.
// Depends on lpp_pkg.
module lpp_front #(
	parameter int INDEX_WIDTH = 12
) (
	input  lpp_pkg::lpp_in_t   in_beat,
	input  lpp_pkg::lpp_cfg_t  cfg,
	output lpp_pkg::lpp_work_t work
);

	localparam logic [11:0] IDX_MASK = (INDEX_WIDTH >= 12) ? 12'hFFF
		: 12'((1 << INDEX_WIDTH) - 1);

	logic [11:0] idx;
	logic [35:0] idx_prod;
	logic [15:0] rng;

	assign idx = in_beat.sample_index & IDX_MASK;
	assign idx_prod = idx * cfg.angle_step;
	assign rng = in_beat.range_sample;

	// binary angle wraps at 2^24
	always_comb begin
		work.range_sample = rng;
		work.scan_last    = in_beat.scan_last;
		work.theta        = cfg.angle_start + idx_prod[23:0] + cfg.rotation;
		work.range_ok     = (rng > cfg.sensor_range_min) && (rng < cfg.sensor_range_max)
			&& (rng >= cfg.gate_min) && (rng <= cfg.gate_max);
	end

endmodule

@@ rtl/lpp_queue.sv @@
// Four-entry queue between front and back ends.
// Depends on lpp_pkg.
module lpp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  lpp_pkg::lpp_work_t wr_data,
	output logic               full,
	input  logic               rd_en,
	output lpp_pkg::lpp_work_t rd_data,
	output logic               rd_valid
);

	localparam int DEPTH = 4;

	lpp_pkg::lpp_work_t mem_q [DEPTH];
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] cnt_q;
	logic       do_wr, do_rd;

	assign full     = (cnt_q == 3'(DEPTH));
	assign rd_valid = (cnt_q != 3'd0);
	assign rd_data  = mem_q[rptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= wptr_q + 2'd1;
			if (do_rd) rptr_q <= rptr_q + 2'd1;
			cnt_q <= cnt_q + 3'(do_wr) - 3'(do_rd);
		end
	end

endmodule

@@ rtl/lpp_back.sv @@
// Back end: CORDIC sine/cosine, scale multiplies, restoring divide by the
// sensor maximum, pixel bounds check and the output register. Depends on lpp_pkg.
module lpp_back #(
	parameter int MAX_IMAGE_SIZE = 4096,
	parameter int TRIG_STAGES    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lpp_pkg::lpp_cfg_t  cfg,
	input  logic               in_valid,
	input  lpp_pkg::lpp_work_t in_work,
	output logic               in_take,
	output logic               out_valid,
	input  logic               out_take,
	output lpp_pkg::lpp_out_t  out_beat
);

	localparam int QW = lpp_pkg::QUOT_W;

	typedef struct packed {
		logic [15:0] range_sample;
		logic [1:0]  quad;
		logic        range_ok;
		logic        scan_last;
	} sb_t;

	typedef struct packed {
		logic csgn;
		logic ssgn;
		logic range_ok;
		logic scan_last;
	} dsb_t;

	logic en;

	// CORDIC stage registers
	logic signed [32:0] cx_s [TRIG_STAGES];
	logic signed [32:0] cy_s [TRIG_STAGES];
	logic signed [23:0] cz_s [TRIG_STAGES];
	sb_t                csb_s [TRIG_STAGES];
	logic               cvld_s [TRIG_STAGES];

	// round, multiply stages
	logic [15:0] cmag_s1, smag_s1;
	sb_t         sb_s1;
	logic        vld_s1;
	logic [31:0] pc_s2, ps_s2;
	dsb_t        dsb_s1, dsb_s2, dsb_s3;
	logic        vld_s2, vld_s3;
	logic [44:0] nc_s3, ns_s3;

	// divide stages
	logic [28:0]   remc_s [QW+1];
	logic [28:0]   rems_s [QW+1];
	logic [QW-1:0] qc_s   [QW+1];
	logic [QW-1:0] qs_s   [QW+1];
	dsb_t          ddsb_s [QW+1];
	logic          dvld_s [QW+1];

	// round, saturate, quadrant map
	logic signed [15:0] cq, sq;
	logic signed [16:0] tc, ts;

	// final
	logic signed [13:0] pxs, pys;
	logic [14:0]        lim;
	logic               fin_ok;
	lpp_pkg::lpp_out_t  fin;
	lpp_pkg::lpp_out_t  out_q;
	logic               out_vld_q;

	function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
		logic signed [33:0] r;
		r = (34'(v) + 34'sd16384) >>> 15;
		if (r > 34'sd32767) return 16'sd32767;
		if (r < -34'sd32768) return -16'sd32768;
		return r[15:0];
	endfunction

	function automatic logic signed [23:0] atan24(input int i);
		return $signed({2'b00, lpp_pkg::atan_val(i)});
	endfunction

	// pipeline advances when the output register is free or being drained
	assign en        = !out_vld_q || out_take;
	assign in_take   = en && in_valid;
	assign out_valid = out_vld_q;
	assign out_beat  = out_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TRIG_STAGES; k++) cvld_s[k] <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			cvld_s[0] <= in_valid;
			for (int k = 1; k < TRIG_STAGES; k++) cvld_s[k] <= cvld_s[k-1];
			vld_s1 <= cvld_s[TRIG_STAGES-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			out_vld_q <= dvld_s[QW];
		end
	end

	// first CORDIC rotation from x = 1/K, y = 0
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0]  <= lpp_pkg::CORDIC_X0;
			cy_s[0]  <= lpp_pkg::CORDIC_X0;
			cz_s[0]  <= $signed({2'b00, in_work.theta[21:0]}) - atan24(0);
			csb_s[0] <= '{range_sample: in_work.range_sample, quad: in_work.theta[23:22],
				range_ok: in_work.range_ok, scan_last: in_work.scan_last};
		end
	end

	// remaining CORDIC rotations, one per stage
	for (genvar k = 1; k < TRIG_STAGES; k++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_s[k-1][23]) begin
					cx_s[k] <= cx_s[k-1] - (cy_s[k-1] >>> k);
					cy_s[k] <= cy_s[k-1] + (cx_s[k-1] >>> k);
					cz_s[k] <= cz_s[k-1] - atan24(k);
				end else begin
					cx_s[k] <= cx_s[k-1] + (cy_s[k-1] >>> k);
					cy_s[k] <= cy_s[k-1] - (cx_s[k-1] >>> k);
					cz_s[k] <= cz_s[k-1] + atan24(k);
				end
				csb_s[k] <= csb_s[k-1];
			end
		end
	end

	// Q1.15 rounding and quadrant mapping
	always_comb begin
		cq = to_q15(cx_s[TRIG_STAGES-1]);
		sq = to_q15(cy_s[TRIG_STAGES-1]);
		case (csb_s[TRIG_STAGES-1].quad)
			2'd0: begin tc = 17'(cq);  ts = 17'(sq);  end
			2'd1: begin tc = -17'(sq); ts = 17'(cq);  end
			2'd2: begin tc = -17'(cq); ts = -17'(sq); end
			default: begin tc = 17'(sq); ts = -17'(cq); end
		endcase
	end

	// magnitude and sign, then the two multiplies
	always_ff @(posedge clk) begin
		if (en) begin
			cmag_s1 <= tc[16] ? 16'(-tc) : tc[15:0];
			smag_s1 <= ts[16] ? 16'(-ts) : ts[15:0];
			sb_s1   <= csb_s[TRIG_STAGES-1];
			dsb_s1  <= '{csgn: tc[16], ssgn: ts[16],
				range_ok: csb_s[TRIG_STAGES-1].range_ok,
				scan_last: csb_s[TRIG_STAGES-1].scan_last};
			pc_s2   <= sb_s1.range_sample * cmag_s1;
			ps_s2   <= sb_s1.range_sample * smag_s1;
			dsb_s2  <= dsb_s1;
			nc_s3   <= pc_s2 * cfg.image_size;
			ns_s3   <= ps_s2 * cfg.image_size;
			dsb_s3  <= dsb_s2;
		end
	end

	// divide entry: drop the 2^16 part of the denominator
	always_comb begin
		remc_s[0] = nc_s3[44:16];
		rems_s[0] = ns_s3[44:16];
		qc_s[0]   = '0;
		qs_s[0]   = '0;
		ddsb_s[0] = dsb_s3;
		dvld_s[0] = vld_s3;
	end

	// restoring divide by sensor_range_max, one quotient bit per stage
	for (genvar j = 0; j < QW; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[j+1] <= 1'b0;
			end else if (en) begin
				dvld_s[j+1] <= dvld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (remc_s[j] >= (29'(cfg.sensor_range_max) << (QW-1-j))) begin
					remc_s[j+1] <= remc_s[j] - (29'(cfg.sensor_range_max) << (QW-1-j));
					qc_s[j+1]   <= {qc_s[j][QW-2:0], 1'b1};
				end else begin
					remc_s[j+1] <= remc_s[j];
					qc_s[j+1]   <= {qc_s[j][QW-2:0], 1'b0};
				end
				if (rems_s[j] >= (29'(cfg.sensor_range_max) << (QW-1-j))) begin
					rems_s[j+1] <= rems_s[j] - (29'(cfg.sensor_range_max) << (QW-1-j));
					qs_s[j+1]   <= {qs_s[j][QW-2:0], 1'b1};
				end else begin
					rems_s[j+1] <= rems_s[j];
					qs_s[j+1]   <= {qs_s[j][QW-2:0], 1'b0};
				end
				ddsb_s[j+1] <= ddsb_s[j];
			end
		end
	end

	// signed quotient plus half the image, bounds check
	always_comb begin
		pxs = (ddsb_s[QW].csgn ? -$signed({2'b00, qc_s[QW]}) : $signed({2'b00, qc_s[QW]}))
			+ $signed({2'b00, cfg.image_size[12:1]});
		pys = (ddsb_s[QW].ssgn ? -$signed({2'b00, qs_s[QW]}) : $signed({2'b00, qs_s[QW]}))
			+ $signed({2'b00, cfg.image_size[12:1]});
		lim = (15'(cfg.image_size) > 15'(MAX_IMAGE_SIZE)) ? 15'(MAX_IMAGE_SIZE)
			: 15'(cfg.image_size);
		fin_ok = ddsb_s[QW].range_ok && !pxs[13] && !pys[13]
			&& (15'(pxs[12:0]) < lim) && (15'(pys[12:0]) < lim);
		fin.pixel_x     = fin_ok ? pxs[11:0] : 12'd0;
		fin.pixel_y     = fin_ok ? pys[11:0] : 12'd0;
		fin.point_valid = fin_ok;
		fin.scan_end    = ddsb_s[QW].scan_last;
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) out_q <= fin;
	end

endmodule

@@ rtl/lidar_polar_to_pixel_unit.sv @@
// Lidar polar-to-pixel unit: one range sample in, one pixel result out.
// Depends on lpp_pkg, lpp_front, lpp_queue, lpp_back.
//
// Accepts one sample per clock while the queue is not full and returns one
// result per clock once the pipeline is full, as long as results are popped.
// A sample passes one rotation per CORDIC stage, rounding, two multiply
// stages, twelve restoring divide stages and the output register. A four-beat
// queue between the angle/gate front end and the arithmetic pipeline absorbs
// result-side stalls; the pipeline holds while the output register waits to
// be popped. The user must write registers through the cfg port only while no
// sample is in flight; the block itself does not enforce this.
module lidar_polar_to_pixel_unit #(
	parameter int MAX_IMAGE_SIZE = 4096,
	parameter int INDEX_WIDTH    = 12,
	parameter int TRIG_STAGES    = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  lpp_pkg::lpp_in_t                 in_item,
	output logic                             empty,
	input  logic                             pop,
	output lpp_pkg::lpp_out_t                out_item,
	input  logic                             cfg_we,
	input  logic [lpp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [lpp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	lpp_pkg::lpp_cfg_t  cfg_q;
	lpp_pkg::lpp_work_t work, qhead;
	logic               qvalid, qtake, ovalid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_range_min <= 16'd205;
			cfg_q.sensor_range_max <= 16'd3584;
			cfg_q.gate_min         <= 16'd0;
			cfg_q.gate_max         <= 16'd65535;
			cfg_q.angle_start      <= 24'd0;
			cfg_q.angle_step       <= 24'd46603;
			cfg_q.rotation         <= 24'd0;
			cfg_q.image_size       <= 13'd1000;
		end else if (cfg_we) begin
			case (cfg_addr)
				lpp_pkg::REG_SENSOR_MIN:  cfg_q.sensor_range_min <= cfg_wdata[15:0];
				lpp_pkg::REG_SENSOR_MAX:  cfg_q.sensor_range_max <= cfg_wdata[15:0];
				lpp_pkg::REG_GATE_MIN:    cfg_q.gate_min         <= cfg_wdata[15:0];
				lpp_pkg::REG_GATE_MAX:    cfg_q.gate_max         <= cfg_wdata[15:0];
				lpp_pkg::REG_ANGLE_START: cfg_q.angle_start      <= cfg_wdata;
				lpp_pkg::REG_ANGLE_STEP:  cfg_q.angle_step       <= cfg_wdata;
				lpp_pkg::REG_ROTATION:    cfg_q.rotation         <= cfg_wdata;
				lpp_pkg::REG_IMAGE_SIZE:  cfg_q.image_size       <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	lpp_front #(.INDEX_WIDTH(INDEX_WIDTH)) u_front (
		.in_beat (in_item),
		.cfg     (cfg_q),
		.work    (work)
	);

	lpp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  (work),
		.full     (full),
		.rd_en    (qtake),
		.rd_data  (qhead),
		.rd_valid (qvalid)
	);

	lpp_back #(.MAX_IMAGE_SIZE(MAX_IMAGE_SIZE), .TRIG_STAGES(TRIG_STAGES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (qvalid),
		.in_work   (qhead),
		.in_take   (qtake),
		.out_valid (ovalid),
		.out_take  (pop),
		.out_beat  (out_item)
	);

	assign empty = !ovalid;

endmodule

@@ rtl/lpp_checker.sv @@
// Port-level checks for the lidar polar-to-pixel unit, bound to the top level.
// Depends on lpp_pkg and lidar_polar_to_pixel_unit.
module lpp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           push,
	input logic                           full,
	input lpp_pkg::lpp_in_t               in_item,
	input logic                           empty,
	input logic                           pop,
	input lpp_pkg::lpp_out_t              out_item,
	input logic                           cfg_we,
	input logic [lpp_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input logic [lpp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// a waiting result beat holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_item)))
		else $error("result beat changed while waiting");

	// rejected points carry zero pixels
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_item.point_valid) |-> (out_item.pixel_x == 12'd0
			&& out_item.pixel_y == 12'd0))
		else $error("invalid point with nonzero pixel");

	// nothing to pop during reset
	a_rst: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// a result right after reset needs an earlier accepted beat
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		($past(!arst_n) && arst_n) |-> empty)
		else $error("result without a prior input beat");

endmodule

bind lidar_polar_to_pixel_unit lpp_checker u_lpp_checker (.*);
